/* rtl/core/rqsi_pkg.sv */
// Shared types and constants for the ready-queue sorted-insert engine.
package rqsi_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 16;
    localparam int LIFE_W          = 24;
    localparam int SLOT_W          = 4;
    localparam int PADDR_W         = 3;

    localparam logic [PADDR_W-1:0] REG_POLICY = 3'd0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic {
        POL_FCFS = 1'b0,
        POL_SPN  = 1'b1
    } t_policy;

    typedef struct packed {
        logic [ID_W-1:0]   process_id;
        logic [LIFE_W-1:0] lifetime;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   head_id;
    } t_out_item;

    typedef struct packed {
        logic    do_ins;
        t_policy policy;
    } t_cell_ctl;

endpackage

/* rtl/core/ready_queue_sorted_insert_top.sv */
// Top level of the ready-queue sorted-insert engine.
//
// Input channel: i_in_valid / o_in_stall carry one item (process id and
// lifetime in 16.8 fixed point). Each item yields exactly one result item
// (status, landing slot, head id) on o_out_valid / i_out_stall.
// The queue is a row of cells; each cell compares its entry with the new
// lifetime and the whole row inserts or shifts in the accept cycle.
// Latency: the result appears in the cycle after the item is accepted.
// Throughput: one item per cycle while the result side takes every item;
// the output register holds one result, so a stalled result stalls input.
// The policy register (APB, byte address 0) selects append (0) or ordered
// insert (1); write it only while the block is idle.
// Reset clears the fill count, the policy and the output valid; entries
// need no clearing since only slots below the fill count are read.
module ready_queue_sorted_insert_top
    import rqsi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_policy           r_policy;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    t_out_item         r_out_item;
    t_out_item         n_out_item;

    logic              w_accept;
    logic              w_item_ok;
    logic              w_full;
    t_cell_ctl         w_ctl;
    logic [SLOT_W-1:0] w_slot;

    logic [ID_W-1:0]   w_id     [QUEUE_DEPTH];
    logic [LIFE_W-1:0] w_life   [QUEUE_DEPTH];
    logic [SLOT_W-1:0] w_slotk  [QUEUE_DEPTH];
    logic              w_passed [QUEUE_DEPTH+1];

    assign pready = 1'b1;
    assign prdata = (paddr == REG_POLICY) ? {31'b0, r_policy} : '0;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_item_ok   = (i_in_item.process_id != '0) && (i_in_item.lifetime != '0);
    assign w_full      = (r_count == FULL_CNT);
    assign w_ctl.do_ins = w_accept && w_item_ok && !w_full;
    assign w_ctl.policy = r_policy;
    assign w_passed[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [ID_W-1:0]   w_prev_id;
        logic [LIFE_W-1:0] w_prev_life;
        if (g == 0) begin : g_first
            assign w_prev_id   = '0;
            assign w_prev_life = '0;
        end else begin : g_rest
            assign w_prev_id   = w_id[g-1];
            assign w_prev_life = w_life[g-1];
        end
        rqsi_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_new       (i_in_item),
            .i_prev_id   (w_prev_id),
            .i_prev_life (w_prev_life),
            .i_passed    (w_passed[g]),
            .o_passed    (w_passed[g+1]),
            .o_slot      (w_slotk[g]),
            .o_id        (w_id[g]),
            .o_life      (w_life[g])
        );
    end

    always_comb begin
        w_slot = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_slot = w_slot | w_slotk[k];
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.do_ins) begin
            n_count = r_count + CW'(1);
        end
    end

    always_comb begin
        n_out_item.slot = w_slot;
        if (!w_item_ok) begin
            n_out_item.status = ST_INVALID;
        end else if (w_full) begin
            n_out_item.status = ST_FULL;
        end else begin
            n_out_item.status = ST_OK;
        end
        if (w_ctl.do_ins && w_passed[1]) begin
            n_out_item.head_id = i_in_item.process_id;
        end else if (r_count == '0) begin
            n_out_item.head_id = '0;
        end else begin
            n_out_item.head_id = w_id[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POL_FCFS;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == REG_POLICY) begin
                r_policy <= t_policy'(pwdata[0]);
            end
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* rtl/core/rqsi_cell.sv */
// One queue cell: holds an entry, compares it with the new item and shifts.
module rqsi_cell
    import rqsi_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [CW-1:0]     i_count,
    input  t_in_item          i_new,
    input  logic [ID_W-1:0]   i_prev_id,
    input  logic [LIFE_W-1:0] i_prev_life,
    input  logic              i_passed,
    output logic              o_passed,
    output logic [SLOT_W-1:0] o_slot,
    output logic [ID_W-1:0]   o_id,
    output logic [LIFE_W-1:0] o_life
);

    localparam logic [CW-1:0]     MY_IDX  = CW'(IDX);
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX % 16);

    logic [ID_W-1:0]   r_id;
    logic [LIFE_W-1:0] r_life;
    logic [ID_W-1:0]   n_id;
    logic [LIFE_W-1:0] n_life;
    logic              w_gt;
    logic              w_here;

    assign w_gt   = (i_ctl.policy == POL_SPN) && (MY_IDX < i_count)
                    && (r_life > i_new.lifetime);
    assign w_here = i_ctl.do_ins && !i_passed && (w_gt || (MY_IDX == i_count));

    assign o_passed = i_passed || w_here;
    assign o_slot   = w_here ? MY_SLOT : '0;
    assign o_id     = r_id;
    assign o_life   = r_life;

    always_comb begin
        n_id   = r_id;
        n_life = r_life;
        if (w_here) begin
            n_id   = i_new.process_id;
            n_life = i_new.lifetime;
        end else if (i_passed) begin
            n_id   = i_prev_id;
            n_life = i_prev_life;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_life <= n_life;
    end

endmodule
